// File: rtl/tile_cache_farthest_eviction_macros.svh
// Assertion macros shared by the tile cache modules.
`ifndef TILE_CACHE_FARTHEST_EVICTION_MACROS_SVH
`define TILE_CACHE_FARTHEST_EVICTION_MACROS_SVH

`ifndef NO_ASSERTIONS

// Require post in the same cycle whenever pre holds.
`define TCFE_ASSERT_SAME(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("tile cache assertion failed");

// Require post in the cycle after pre holds.
`define TCFE_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("tile cache assertion failed");

// Forbid a condition at every edge.
`define TCFE_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("tile cache assertion failed");

`else

`define TCFE_ASSERT_SAME(label, clk, rstn, pre, post)
`define TCFE_ASSERT_NEXT(label, clk, rstn, pre, post)
`define TCFE_ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

// File: rtl/tcfe_pkg.sv
// Shared types, codes and defaults of the tile cache.
package tcfe_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int GRID_DEF  = 64;

    // Distance of a slot to the center: two 6-bit differences summed
    localparam int DIST_W = 9;

    typedef enum logic [1:0] {
        ST_HIT    = 2'd0,
        ST_FILL   = 2'd1,
        ST_EVICT  = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [7:0] tile_x;
        logic signed [7:0] tile_z;
        logic              tile_has_data;
        logic [5:0]        center_x;
        logic [5:0]        center_z;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [4:0] slot;
        logic [5:0] evicted_x;
        logic [5:0] evicted_z;
    } resp_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_req;
        logic    start;
        logic    issue;
        logic    evict_pass;
        logic    write;
        logic    load_out;
        status_t status;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic reject;
        logic last;
        logic hit_found;
        logic empty_found;
    } dp_stat_t;

endpackage

// File: rtl/tcfe_ctrl.sv
// Sequencer of the tile cache: request intake, scan passes, update, result transfer.
`include "tile_cache_farthest_eviction_macros.svh"

module tcfe_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output tcfe_pkg::dp_cmd_t  cmd,
    input  tcfe_pkg::dp_stat_t stat
);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_LOOK       = 7'b0000010,
        S_LOOK_WAIT  = 7'b0000100,
        S_DECIDE     = 7'b0001000,
        S_EVICT      = 7'b0010000,
        S_EVICT_WAIT = 7'b0100000,
        S_WRITE      = 7'b1000000
    } state_t;

    // Finished result not yet moved into the output register
    typedef enum logic [1:0] {
        R_EMPTY = 2'b01,
        R_READY = 2'b10
    } res_t;

    state_t             state_reg, state_next;
    res_t               res_reg, res_next;
    tcfe_pkg::status_t  status_reg, status_next;
    logic               m_valid_reg, m_valid_next;
    logic               s_accept;

    assign s_ready  = (state_reg == S_IDLE) && (res_reg == R_EMPTY);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // Sequence one request through lookup, optional eviction scan and update
    always_comb begin
        state_next   = state_reg;
        res_next     = res_reg;
        status_next  = status_reg;
        cmd          = '0;
        cmd.status   = status_reg;
        cmd.evict_pass = (state_reg == S_EVICT) || (state_reg == S_EVICT_WAIT);
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    cmd.load_req = 1'b1;
                    cmd.start    = 1'b1;
                    if (stat.reject) begin
                        status_next = tcfe_pkg::ST_REJECT;
                        res_next    = R_READY;
                    end else begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                cmd.issue = 1'b1;
                if (stat.last) begin
                    state_next = S_LOOK_WAIT;
                end
            end
            S_LOOK_WAIT: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (stat.hit_found) begin
                    status_next = tcfe_pkg::ST_HIT;
                    res_next    = R_READY;
                    state_next  = S_IDLE;
                end else if (stat.empty_found) begin
                    status_next = tcfe_pkg::ST_FILL;
                    state_next  = S_WRITE;
                end else begin
                    status_next = tcfe_pkg::ST_EVICT;
                    cmd.start   = 1'b1;
                    state_next  = S_EVICT;
                end
            end
            S_EVICT: begin
                cmd.issue = 1'b1;
                if (stat.last) begin
                    state_next = S_EVICT_WAIT;
                end
            end
            S_EVICT_WAIT: begin
                state_next = S_WRITE;
            end
            S_WRITE: begin
                cmd.write  = 1'b1;
                res_next   = R_READY;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Move a finished result into the output register once it is free
        if (res_reg == R_READY && (!m_valid_reg || m_ready)) begin
            cmd.load_out = 1'b1;
            res_next     = R_EMPTY;
        end
    end

    assign m_valid_next = cmd.load_out || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            res_reg     <= R_EMPTY;
            status_reg  <= tcfe_pkg::ST_HIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            res_reg     <= res_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `TCFE_ASSERT_NEVER(a_no_overwrite, aclk, aresetn, cmd.load_out && m_valid_reg && !m_ready)
    `TCFE_ASSERT_NEXT(a_reject_direct, aclk, aresetn, s_accept && stat.reject, state_reg == S_IDLE && res_reg == R_READY)
    `TCFE_ASSERT_SAME(a_write_kind, aclk, aresetn, cmd.write, status_reg == tcfe_pkg::ST_FILL || status_reg == tcfe_pkg::ST_EVICT)

endmodule

// File: rtl/tcfe_datapath.sv
// Tile cache datapath: slot store, valid bits, scan compare stage and result register.
`include "tile_cache_farthest_eviction_macros.svh"

module tcfe_datapath #(
    parameter int SLOTS = tcfe_pkg::SLOTS_DEF,
    parameter int GRID  = tcfe_pkg::GRID_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tcfe_pkg::req_t     s_data,
    output tcfe_pkg::resp_t    m_data,
    input  tcfe_pkg::dp_cmd_t  cmd,
    output tcfe_pkg::dp_stat_t stat
);

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int COORD_W = (GRID > 2) ? $clog2(GRID) : 1;
    localparam int WORD_W  = 2 * COORD_W;
    localparam logic [7:0]         GRID_LIM = 8'(GRID);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(SLOTS - 1);

    logic [WORD_W-1:0]  mem [SLOTS];
    logic [SLOTS-1:0]   valid_reg;

    logic [COORD_W-1:0] req_x_reg, req_z_reg;
    logic [5:0]         cx_reg, cz_reg;

    logic [IDX_W-1:0]   cnt_reg;
    logic [WORD_W-1:0]  rd_word_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               cmp_live_reg;

    logic               hit_found_reg, empty_found_reg;
    logic [IDX_W-1:0]   hit_idx_reg, empty_idx_reg, best_idx_reg;
    logic [tcfe_pkg::DIST_W-1:0] best_dist_reg;
    logic [WORD_W-1:0]  best_word_reg;

    tcfe_pkg::resp_t    out_reg, out_next;

    logic [COORD_W-1:0] rd_col, rd_row;
    logic [tcfe_pkg::DIST_W-1:0] col_a, col_b, row_a, row_b, dcol, drow, slot_dist;
    logic               match;
    logic [IDX_W-1:0]   tgt_idx;
    logic [IDX_W-1:0]   sel_idx;
    logic [7:0]         slot_wide, ex_wide, ez_wide;
    logic               x_out, z_out;

    // Reject when off the grid or without data
    assign x_out = s_data.tile_x[7] || ({1'b0, s_data.tile_x[6:0]} >= GRID_LIM);
    assign z_out = s_data.tile_z[7] || ({1'b0, s_data.tile_z[6:0]} >= GRID_LIM);

    assign stat.reject      = x_out || z_out || !s_data.tile_has_data;
    assign stat.last        = (cnt_reg == LAST_IDX);
    assign stat.hit_found   = hit_found_reg;
    assign stat.empty_found = empty_found_reg;

    // Hold the request
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_x_reg <= COORD_W'(s_data.tile_x);
            req_z_reg <= COORD_W'(s_data.tile_z);
            cx_reg    <= s_data.center_x;
            cz_reg    <= s_data.center_z;
        end
    end

    // Slot store: one write port, one registered read port driven by the scan counter
    assign tgt_idx = (cmd.status == tcfe_pkg::ST_FILL) ? empty_idx_reg : best_idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[tgt_idx] <= {req_x_reg, req_z_reg};
        end
        rd_word_reg  <= mem[cnt_reg];
        rd_valid_reg <= valid_reg[cnt_reg];
        cmp_idx_reg  <= cnt_reg;
    end

    // Valid bits and scan counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            cnt_reg      <= '0;
            cmp_live_reg <= 1'b0;
        end else begin
            if (cmd.write) begin
                valid_reg[tgt_idx] <= 1'b1;
            end
            if (cmd.start) begin
                cnt_reg <= '0;
            end else if (cmd.issue) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            cmp_live_reg <= cmd.issue;
        end
    end

    // Score the slot just read
    assign rd_col = rd_word_reg[WORD_W-1:COORD_W];
    assign rd_row = rd_word_reg[COORD_W-1:0];
    assign match  = (rd_col == req_x_reg) && (rd_row == req_z_reg);

    assign col_a = tcfe_pkg::DIST_W'(rd_col);
    assign col_b = tcfe_pkg::DIST_W'(cx_reg);
    assign row_a = tcfe_pkg::DIST_W'(rd_row);
    assign row_b = tcfe_pkg::DIST_W'(cz_reg);
    assign dcol  = (col_a > col_b) ? (col_a - col_b) : (col_b - col_a);
    assign drow  = (row_a > row_b) ? (row_a - row_b) : (row_b - row_a);
    assign slot_dist = dcol + drow;

    // Track first hit, first empty slot and farthest slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end else if (cmd.start) begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end else if (cmp_live_reg && !cmd.evict_pass) begin
            if (rd_valid_reg && match && !hit_found_reg) begin
                hit_found_reg <= 1'b1;
            end
            if (!rd_valid_reg && !empty_found_reg) begin
                empty_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_live_reg && !cmd.evict_pass) begin
            if (rd_valid_reg && match && !hit_found_reg) begin
                hit_idx_reg <= cmp_idx_reg;
            end
            if (!rd_valid_reg && !empty_found_reg) begin
                empty_idx_reg <= cmp_idx_reg;
            end
        end
        // Slot zero seeds the search; later slots win only when strictly farther
        if (cmp_live_reg && cmd.evict_pass) begin
            if (cmp_idx_reg == '0 || slot_dist > best_dist_reg) begin
                best_dist_reg <= slot_dist;
                best_idx_reg  <= cmp_idx_reg;
                best_word_reg <= rd_word_reg;
            end
        end
    end

    // Build the result and hold it until transfer
    always_comb begin
        case (cmd.status)
            tcfe_pkg::ST_HIT:   sel_idx = hit_idx_reg;
            tcfe_pkg::ST_FILL:  sel_idx = empty_idx_reg;
            tcfe_pkg::ST_EVICT: sel_idx = best_idx_reg;
            default:            sel_idx = '0;
        endcase
        slot_wide = 8'(sel_idx);
        ex_wide   = 8'(best_word_reg[WORD_W-1:COORD_W]);
        ez_wide   = 8'(best_word_reg[COORD_W-1:0]);
        out_next.status    = cmd.status;
        out_next.slot      = slot_wide[4:0];
        out_next.evicted_x = (cmd.status == tcfe_pkg::ST_EVICT) ? ex_wide[5:0] : 6'd0;
        out_next.evicted_z = (cmd.status == tcfe_pkg::ST_EVICT) ? ez_wide[5:0] : 6'd0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    `TCFE_ASSERT_SAME(a_fill_empty, aclk, aresetn, cmd.write && cmd.status == tcfe_pkg::ST_FILL, !valid_reg[empty_idx_reg])
    `TCFE_ASSERT_SAME(a_evict_full, aclk, aresetn, cmd.write && cmd.status == tcfe_pkg::ST_EVICT, &valid_reg)
    `TCFE_ASSERT_NEVER(a_scan_overrun, aclk, aresetn, cmd.issue && cmd.start)

endmodule

// File: rtl/tile_cache_farthest_eviction.sv
// Tile cache top level: fully associative slots with farthest-from-center replacement.
//
// Input channel s_valid/s_ready/s_data carries a tile request (coordinate, data flag,
// center tile). Output channel m_valid/m_ready/m_data carries one result per request:
// hit, fill of the lowest empty slot, replacement of the farthest slot, or reject.
// Requests are handled one at a time by a sequencer that scans the slot store through
// its single read port, one slot per cycle.
// A reject skips the scans; a hit ends after the lookup scan, a fill adds a write of
// the lowest empty slot, and a replacement a second scan that scores distances.
// Reset clears all valid bits at once; no clearing pass is needed.
// A result waiting in the output register does not block the next request; if the
// receiver stalls, the next finished result waits inside and s_ready stays low
// until the output register is free.
module tile_cache_farthest_eviction #(
    parameter int SLOTS = tcfe_pkg::SLOTS_DEF,
    parameter int GRID  = tcfe_pkg::GRID_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tcfe_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output tcfe_pkg::resp_t m_data
);

    tcfe_pkg::dp_cmd_t  cmd;
    tcfe_pkg::dp_stat_t stat;

    tcfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    tcfe_datapath #(
        .SLOTS (SLOTS),
        .GRID  (GRID)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

// File: test/tb.sv
// Self-checking testbench for the tile cache with farthest-from-center replacement.
`timescale 1ns / 100ps

module tb;

    localparam int SLOTS = tcfe_pkg::SLOTS_DEF;
    localparam int GRID  = tcfe_pkg::GRID_DEF;
    // Longest request: a replacement takes two scans of the slot store
    localparam int DRAIN_CYCLES = 2 * SLOTS + 16;
    localparam int RANDOM_REQUESTS = 700;

    logic            aclk    = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    tcfe_pkg::req_t  s_data  = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    tcfe_pkg::resp_t m_data;

    // Set during a stretch of transfers with no idling on either side
    bit no_idle = 1'b0;

    // Track the cached tiles and hold the results still owed by the block
    class tile_cache_board;
        bit              occupied [SLOTS];
        bit [5:0]        held_col [SLOTS];
        bit [5:0]        held_row [SLOTS];
        tcfe_pkg::resp_t expected_resp [$];
        int              mismatches = 0;

        function tcfe_pkg::resp_t predict_lookup(tcfe_pkg::req_t r);
            tcfe_pkg::resp_t res;
            int    x, z, cx, cz;
            int    empty_idx, far_idx, far_dist, slot_dist, dc, dz;
            res = '0;
            x  = $signed(r.tile_x);
            z  = $signed(r.tile_z);
            cx = int'(r.center_x);
            cz = int'(r.center_z);
            if (x < 0 || x >= GRID || z < 0 || z >= GRID || !r.tile_has_data) begin
                res.status = tcfe_pkg::ST_REJECT;
                return res;
            end
            // Look for a hit and remember the lowest empty slot
            empty_idx = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (occupied[i]) begin
                    if (int'(held_col[i]) == x && int'(held_row[i]) == z) begin
                        res.status = tcfe_pkg::ST_HIT;
                        res.slot   = i[4:0];
                        return res;
                    end
                end else if (empty_idx < 0) begin
                    empty_idx = i;
                end
            end
            if (empty_idx >= 0) begin
                res.status = tcfe_pkg::ST_FILL;
                res.slot   = empty_idx[4:0];
            end else begin
                // Pick the farthest slot; strict compare keeps the lowest index on a tie
                far_dist = 0;
                far_idx  = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    dc        = int'(held_col[i]) - cx;
                    dz        = int'(held_row[i]) - cz;
                    slot_dist = (dc < 0 ? -dc : dc) + (dz < 0 ? -dz : dz);
                    if (slot_dist > far_dist) begin
                        far_dist = slot_dist;
                        far_idx  = i;
                    end
                end
                res.status    = tcfe_pkg::ST_EVICT;
                res.slot      = far_idx[4:0];
                res.evicted_x = held_col[far_idx];
                res.evicted_z = held_row[far_idx];
            end
            occupied[res.slot] = 1'b1;
            held_col[res.slot] = x[5:0];
            held_row[res.slot] = z[5:0];
            return res;
        endfunction

        function void note_request(tcfe_pkg::req_t r);
            expected_resp.push_back(predict_lookup(r));
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_response(tcfe_pkg::resp_t got);
            tcfe_pkg::resp_t want;
            if (expected_resp.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
                return;
            end
            want = expected_resp.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %s, want %s", got.status.name(),
                                          want.status.name()));
            if (got.slot !== want.slot)
                report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
            if (got.evicted_x !== want.evicted_x)
                report_mismatch($sformatf("evicted_x %0d, want %0d",
                                          got.evicted_x, want.evicted_x));
            if (got.evicted_z !== want.evicted_z)
                report_mismatch($sformatf("evicted_z %0d, want %0d",
                                          got.evicted_z, want.evicted_z));
        endtask

        function int waiting();
            return expected_resp.size();
        endfunction
    endclass

    tile_cache_board board = new();

    tile_cache_farthest_eviction #(
        .SLOTS(SLOTS),
        .GRID (GRID)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Stall the result channel at random outside the quiet stretch
    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 9);
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_response(m_data);
    end

    function automatic tcfe_pkg::req_t make_request(logic signed [7:0] x,
                                                    logic signed [7:0] z, logic has,
                                                    logic [5:0] cx, logic [5:0] cz);
        tcfe_pkg::req_t r;
        r.tile_x        = x;
        r.tile_z        = z;
        r.tile_has_data = has;
        r.center_x      = cx;
        r.center_z      = cz;
        return r;
    endfunction

    // Present one request and hold it until the transfer
    task automatic send_request(input tcfe_pkg::req_t r);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        board.note_request(r);
    endtask

    // Build a random request: mostly well-formed tiles from a small working set
    function automatic tcfe_pkg::req_t random_request();
        tcfe_pkg::req_t r;
        int unsigned    pick;
        pick = $urandom_range(99);
        r.center_x = 6'($urandom_range(63));
        r.center_z = 6'($urandom_range(63));
        if ($urandom_range(99) < 25) begin
            r.center_x = $urandom_range(1) ? 6'd63 : 6'd0;
            r.center_z = $urandom_range(1) ? 6'd63 : 6'd0;
        end
        if (pick < 10) begin
            // noise across the whole coordinate range
            r.tile_x        = 8'($urandom_range(255));
            r.tile_z        = 8'($urandom_range(255));
            r.tile_has_data = 1'($urandom_range(1));
        end else if (pick < 15) begin
            // in-grid tile that the map marks as absent
            r.tile_x        = 8'($urandom_range(GRID - 1));
            r.tile_z        = 8'($urandom_range(GRID - 1));
            r.tile_has_data = 1'b0;
        end else if (pick < 30) begin
            r.tile_x        = 8'($urandom_range(GRID - 1));
            r.tile_z        = 8'($urandom_range(GRID - 1));
            r.tile_has_data = 1'b1;
        end else begin
            // working set a bit larger than the cache: hits, fills and replacements
            r.tile_x        = 8'($urandom_range(7));
            r.tile_z        = 8'($urandom_range(5));
            r.tile_has_data = 1'b1;
        end
        return r;
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: grid edges, missing data, fills, hits
        send_request(make_request(-8'sd128, 8'sd0, 1'b1, 6'd0, 6'd0));
        send_request(make_request(8'sd64, 8'sd5, 1'b1, 6'd0, 6'd0));
        send_request(make_request(8'sd127, 8'sd127, 1'b1, 6'd63, 6'd63));
        send_request(make_request(8'sd3, -8'sd1, 1'b1, 6'd0, 6'd0));
        send_request(make_request(8'sd3, 8'sd64, 1'b1, 6'd0, 6'd0));
        send_request(make_request(-8'sd1, -8'sd128, 1'b1, 6'd0, 6'd0));
        send_request(make_request(8'sd3, 8'sd3, 1'b0, 6'd0, 6'd0));
        send_request(make_request(8'sd0, 8'sd0, 1'b1, 6'd0, 6'd0));
        send_request(make_request(8'sd63, 8'sd63, 1'b1, 6'd0, 6'd0));
        send_request(make_request(8'sd63, 8'sd0, 1'b1, 6'd63, 6'd63));
        send_request(make_request(8'sd0, 8'sd63, 1'b1, 6'd63, 6'd0));
        send_request(make_request(8'sd63, 8'sd63, 1'b1, 6'd0, 6'd63));
        send_request(make_request(8'sd0, 8'sd0, 1'b1, 6'd31, 6'd31));
        send_request(make_request(8'sd0, 8'sd0, 1'b0, 6'd31, 6'd31));
        send_request(make_request(8'sd0, 8'sd62, 1'b1, 6'd42, 6'd21));
        send_request(make_request(8'sd0, 8'sd62, 1'b1, 6'd21, 6'd42));

        // Random phase with a quiet stretch in the middle
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            no_idle = (n >= 250 && n < 400);
            send_request(random_request());
        end
        no_idle = 1'b0;
        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain outstanding results, then give stray ones a chance to show up
        while (board.waiting() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/tcfe_pkg.sv
rtl/tcfe_ctrl.sv
rtl/tcfe_datapath.sv
rtl/tile_cache_farthest_eviction.sv
test/tb.sv
